@@ hw/rtl/kea_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the spanning-tree edge acceptor.
// No dependencies; every other file of the block imports this package.
package kea_pkg;

    localparam int VERTICES = 64;
    localparam int VIDX_W   = 6;   // vertex index width
    localparam int LABEL_W  = 6;   // component label width, 0 = unlabelled
    localparam int CNT_W    = 7;   // vertex_count register width
    localparam int WEIGHT_W = 8;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(VERTICES);

    localparam logic FUNC_CLEAR = 1'b0;
    localparam logic FUNC_EDGE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_EQ,
        ST_DONE
    } kea_state_t;

    // Broadcast from the controller to every cell in the update cycle
    typedef struct packed {
        logic               clear;
        logic               set_u;
        logic               set_v;
        logic [LABEL_W-1:0] set_val;
        logic               merge;
        logic [LABEL_W-1:0] merge_from;
        logic [LABEL_W-1:0] merge_to;
    } kea_cmd_t;

endpackage

@@ hw/rtl/kea_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for edge items and result items.
// Depends on kea_pkg for field widths.
interface kea_edge_if
    import kea_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                func;
    logic [VIDX_W-1:0]   src_vertex;
    logic [VIDX_W-1:0]   dst_vertex;
    logic [WEIGHT_W-1:0] edge_weight;
    logic                last_edge;

    modport source (output valid, func, src_vertex, dst_vertex, edge_weight, last_edge,
                    input ready);
    modport sink   (input valid, func, src_vertex, dst_vertex, edge_weight, last_edge,
                    output ready);
endinterface

interface kea_result_if
    import kea_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                accepted;
    logic                tree_complete;
    logic [WEIGHT_W-1:0] weight_out;
    logic                bad_vertex;
    logic                final_result;

    modport source (output valid, accepted, tree_complete, weight_out, bad_vertex,
                    final_result, input ready);
    modport sink   (input valid, accepted, tree_complete, weight_out, bad_vertex,
                    final_result, output ready);
endinterface

@@ hw/rtl/kruskal_edge_acceptor.sv @@
`timescale 1ns / 1ps
// Spanning-tree edge acceptor: top level with controller and result register.
// Depends on kea_pkg, kea_if and kea_chain.
//
// Usage:
//   edge_in carries items: func 0 clears every component label, func 1
//   presents an edge (src_vertex, dst_vertex, edge_weight, last_edge) in
//   nondecreasing weight order. result_out returns one item per input item:
//   accepted, tree_complete, bad_vertex, the echoed weight and last flag.
//   A clear item returns an all-zero result.
//   cfg_wr_en/cfg_wr_data write vertex_count; write it only while idle.
// Timing:
//   An accepted item has its result loaded on result_out after these steps:
//   lookup of both endpoint labels, broadcast relabel to all 64 cells,
//   neighbor compare in the cells, and the all-equal reduction.
//   One item is in flight at a time; edge_in.ready returns at the edge that
//   loads the result, so a new item is taken only after the last one's result is loaded.
// Reset and stall:
//   Reset clears all labels and the done flag and sets vertex_count to 64.
//   A stalled receiver holds the result register; the next item may still be
//   taken and is worked up to the final step, where it waits for the slot.
module kruskal_edge_acceptor
    import kea_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CNT_W-1:0]   cfg_wr_data,
    kea_edge_if.sink           edge_in,
    kea_result_if.source       result_out
);

    kea_state_t state_reg, state_next;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    n_eff;
    logic                func_reg;
    logic [VIDX_W-1:0]   u_reg;
    logic [VIDX_W-1:0]   v_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic                last_reg;
    logic                bad_reg;
    logic [LABEL_W-1:0]  lu_reg;
    logic [LABEL_W-1:0]  lv_reg;
    logic                acc_reg;
    logic                acc_next;
    logic                done_reg;

    logic                out_valid_reg;
    logic                out_acc_reg;
    logic                out_tree_reg;
    logic [WEIGHT_W-1:0] out_weight_reg;
    logic                out_bad_reg;
    logic                out_last_reg;

    logic [LABEL_W-1:0]  lu;
    logic [LABEL_W-1:0]  lv;
    logic                all_eq;
    logic                same;
    logic                take;
    logic                load;
    logic                bad_in;
    kea_cmd_t            cmd;

    assign n_eff  = (count_reg > CNT_W'(VERTICES)) ? CNT_W'(VERTICES) : count_reg;
    assign take   = edge_in.valid && edge_in.ready;
    assign bad_in = ({1'b0, edge_in.src_vertex} >= n_eff)
                 || ({1'b0, edge_in.dst_vertex} >= n_eff)
                 || (edge_in.src_vertex == edge_in.dst_vertex);
    assign load   = (state_reg == ST_DONE) && (!out_valid_reg || result_out.ready);
    assign same   = all_eq && (n_eff >= CNT_W'(2));

    assign edge_in.ready = (state_reg == ST_IDLE);

    kea_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .n_cnt  (n_eff),
        .u      (u_reg),
        .v      (v_reg),
        .cmd    (cmd),
        .lu     (lu),
        .lv     (lv),
        .all_eq (all_eq)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   state_next = take ? ST_READ : ST_IDLE;
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_EQ;
            ST_EQ:     state_next = ST_DONE;
            ST_DONE:   state_next = load ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Relabel command, driven only in the update cycle
    always_comb
    begin
        cmd      = '0;
        acc_next = 1'b0;
        if (state_reg == ST_UPDATE)
        begin
            if (func_reg == FUNC_CLEAR)
            begin
                cmd.clear = 1'b1;
            end
            else if (!bad_reg && !done_reg)
            begin
                if ((lu_reg == '0) && (lv_reg == '0))
                begin
                    cmd.set_u   = 1'b1;
                    cmd.set_v   = 1'b1;
                    cmd.set_val = (u_reg > v_reg) ? u_reg : v_reg;
                    acc_next    = 1'b1;
                end
                else if (lv_reg == '0)
                begin
                    cmd.set_v   = 1'b1;
                    cmd.set_val = lu_reg;
                    acc_next    = 1'b1;
                end
                else if (lu_reg == '0)
                begin
                    cmd.set_u   = 1'b1;
                    cmd.set_val = lv_reg;
                    acc_next    = 1'b1;
                end
                else if (lu_reg != lv_reg)
                begin
                    cmd.merge      = 1'b1;
                    cmd.merge_from = lv_reg;
                    cmd.merge_to   = lu_reg;
                    acc_next       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= COUNT_RESET;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
            if (load)
            begin
                if (func_reg == FUNC_CLEAR)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= done_reg | same;
                end
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            func_reg   <= edge_in.func;
            u_reg      <= edge_in.src_vertex;
            v_reg      <= edge_in.dst_vertex;
            weight_reg <= edge_in.edge_weight;
            last_reg   <= edge_in.last_edge;
            bad_reg    <= bad_in;
        end
        if (state_reg == ST_READ)
        begin
            lu_reg <= lu;
            lv_reg <= lv;
        end
        if (state_reg == ST_UPDATE)
        begin
            acc_reg <= acc_next;
        end
        if (load)
        begin
            if (func_reg == FUNC_CLEAR)
            begin
                out_acc_reg    <= 1'b0;
                out_tree_reg   <= 1'b0;
                out_weight_reg <= '0;
                out_bad_reg    <= 1'b0;
                out_last_reg   <= 1'b0;
            end
            else
            begin
                out_acc_reg    <= acc_reg;
                out_tree_reg   <= done_reg | same;
                out_weight_reg <= weight_reg;
                out_bad_reg    <= bad_reg;
                out_last_reg   <= last_reg;
            end
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.accepted      = out_acc_reg;
    assign result_out.tree_complete = out_tree_reg;
    assign result_out.weight_out    = out_weight_reg;
    assign result_out.bad_vertex    = out_bad_reg;
    assign result_out.final_result  = out_last_reg;

endmodule

@@ hw/rtl/kea_cell.sv @@
`timescale 1ns / 1ps
// One vertex cell: holds the component label of one vertex, applies the
// broadcast update and compares its label with the left neighbor. Uses kea_pkg.
module kea_cell
    import kea_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [VIDX_W-1:0]  idx,
    input  logic [CNT_W-1:0]   n_cnt,
    input  logic [VIDX_W-1:0]  u,
    input  logic [VIDX_W-1:0]  v,
    input  kea_cmd_t           cmd,
    input  logic [LABEL_W-1:0] prev_label,
    output logic [LABEL_W-1:0] label,
    output logic [LABEL_W-1:0] hit_u,
    output logic [LABEL_W-1:0] hit_v,
    output logic               eq
);

    logic [LABEL_W-1:0] label_reg;
    logic [LABEL_W-1:0] label_next;
    logic               eq_reg;
    logic               eq_next;
    logic               is_u;
    logic               is_v;

    assign is_u = (idx == u);
    assign is_v = (idx == v);

    always_comb
    begin
        label_next = label_reg;
        if (cmd.clear)
        begin
            label_next = '0;
        end
        else if ((cmd.set_u && is_u) || (cmd.set_v && is_v))
        begin
            label_next = cmd.set_val;
        end
        else if (cmd.merge && (label_reg == cmd.merge_from))
        begin
            label_next = cmd.merge_to;
        end
    end

    // Cell 0 anchors the test with a nonzero label; cells past the count pass
    always_comb
    begin
        if (idx == '0)
        begin
            eq_next = (label_reg != '0);
        end
        else
        begin
            eq_next = ({1'b0, idx} >= n_cnt) || (label_reg == prev_label);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_reg <= '0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            label_reg <= label_next;
            eq_reg    <= eq_next;
        end
    end

    assign label = label_reg;
    assign hit_u = is_u ? label_reg : '0;
    assign hit_v = is_v ? label_reg : '0;
    assign eq    = eq_reg;

endmodule

@@ hw/rtl/kea_chain.sv @@
`timescale 1ns / 1ps
// Row of vertex cells, each passing its label to its right neighbor, plus
// the label lookup and all-equal reductions. Uses kea_pkg and kea_cell.
module kea_chain
    import kea_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CNT_W-1:0]   n_cnt,
    input  logic [VIDX_W-1:0]  u,
    input  logic [VIDX_W-1:0]  v,
    input  kea_cmd_t           cmd,
    output logic [LABEL_W-1:0] lu,
    output logic [LABEL_W-1:0] lv,
    output logic               all_eq
);

    logic [LABEL_W-1:0] labels [VERTICES];
    logic [LABEL_W-1:0] hits_u [VERTICES];
    logic [LABEL_W-1:0] hits_v [VERTICES];
    logic [VERTICES-1:0] eqs;

    for (genvar i = 0; i < VERTICES; i++)
    begin : g_cell
        logic [LABEL_W-1:0] prev;
        if (i == 0)
        begin : g_first
            assign prev = '0;
        end
        else
        begin : g_rest
            assign prev = labels[i-1];
        end

        kea_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .idx        (VIDX_W'(i)),
            .n_cnt      (n_cnt),
            .u          (u),
            .v          (v),
            .cmd        (cmd),
            .prev_label (prev),
            .label      (labels[i]),
            .hit_u      (hits_u[i]),
            .hit_v      (hits_v[i]),
            .eq         (eqs[i])
        );
    end

    // At most one cell matches each index, so an OR picks its label
    always_comb
    begin
        lu = '0;
        lv = '0;
        for (int i = 0; i < VERTICES; i++)
        begin
            lu = lu | hits_u[i];
            lv = lv | hits_v[i];
        end
    end

    assign all_eq = &eqs;

endmodule

@@ hw/rtl/kea_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the edge acceptor, bound to the top level.
// Depends on kea_pkg and kruskal_edge_acceptor.
module kea_checker
    import kea_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic                out_accepted,
    input logic                out_bad,
    input logic [WEIGHT_W-1:0] out_weight
);

    // One item at a time: ready drops right after an item is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("edge item taken while another is in flight");

    // A bad edge is never accepted into the tree
    a_bad_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_bad) |-> !out_accepted)
        else $error("bad edge reported as accepted");

    // A new result cannot appear before the lookup and relabel steps
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !(out_valid && !$past(out_valid))
            ##1 !$rose(out_valid))
        else $error("result appeared too early");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_weight)
            && $stable(out_accepted)))
        else $error("stalled result changed");

endmodule

bind kruskal_edge_acceptor kea_checker u_kea_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (edge_in.valid),
    .in_ready     (edge_in.ready),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .out_accepted (result_out.accepted),
    .out_bad      (result_out.bad_vertex),
    .out_weight   (result_out.weight_out)
);
